FILE: rtl/blfc_pkg.sv
// ----------------------------------------------------------------------------
// Battery level filter and classifier: shared definitions
// Constants, level codes, register indexes and the threshold bundle used by
// the threshold sanitiser and the top level.
// ----------------------------------------------------------------------------
package blfc_pkg;

  // Register map: index of each register (byte address is 4 * index).
  localparam int unsigned AddrW = 4;
  localparam logic [1:0] REG_OKAY = 2'd0;
  localparam logic [1:0] REG_WARN = 2'd1;
  localparam logic [1:0] REG_CRIT = 2'd2;

  // Raw register code that selects the default threshold.
  localparam logic [7:0] RAW_DEFAULT_CODE = 8'hFF;

  // Threshold defaults and clamp limits, in decivolts.
  localparam logic [7:0] OKAY_DEF = 8'd22;
  localparam logic [7:0] OKAY_MIN = 8'd10;
  localparam logic [7:0] OKAY_MAX = 8'd30;
  localparam logic [7:0] WARN_DEF = 8'd20;
  localparam logic [7:0] WARN_MIN = 8'd9;
  localparam logic [7:0] WARN_MAX = 8'd29;
  localparam logic [7:0] CRIT_DEF = 8'd18;
  localparam logic [7:0] CRIT_MIN = 8'd0;
  localparam logic [7:0] CRIT_MAX = 8'd20;

  // Hysteresis in voltage counts, and the filter shift.
  localparam logic [7:0] HYST_COUNTS = 8'd5;
  localparam int unsigned FilterShift = 4;

  // Battery level codes.
  localparam logic [1:0] LVL_FULL  = 2'd0;
  localparam logic [1:0] LVL_HALF  = 2'd1;
  localparam logic [1:0] LVL_EMPTY = 2'd2;
  localparam logic [1:0] LVL_CRIT  = 2'd3;

  // Sanitised thresholds, already scaled to voltage counts.
  typedef struct packed {
    logic [7:0] okay;
    logic [7:0] warn;
    logic [7:0] crit;
    logic       crit_off;
  } thr_t;

  // Substitute the default for the reserved code, then clamp to lo..hi.
  function automatic logic [7:0] pick_and_clamp(input logic [7:0] raw,
                                                input logic [7:0] def,
                                                input logic [7:0] lo,
                                                input logic [7:0] hi);
    logic [7:0] v;
    v = (raw == RAW_DEFAULT_CODE) ? def : raw;
    if (v > hi) begin
      v = hi;
    end else if (v < lo) begin
      v = lo;
    end
    return v;
  endfunction

  // Multiply a clamped threshold (at most 30) by five with a shift and add.
  function automatic logic [7:0] times_five(input logic [7:0] v);
    return {v[5:0], 2'b00} + v;
  endfunction

endpackage

FILE: rtl/battery_level_filter_classifier.sv
// ----------------------------------------------------------------------------
// Battery level filter and classifier
// First-order low-pass filter on battery voltage samples with a four-level
// classifier that applies hysteresis to each threshold.
// ----------------------------------------------------------------------------
// One sample is accepted per clock cycle while results are being taken: the
// sample is first held in an input register, then the filter update and
// level decision are made in one pass into the result register. A result
// that is not taken holds up the input once both registers are full.
// The filter keeps the voltage in 8.8 fixed point and moves a sixteenth of
// the way towards each sample; while it holds zero a sample loads it as is.
// The three thresholds are written in decivolts over the APB port (byte
// addresses 0, 4 and 8), cleaned up and registered; a new value applies to
// samples accepted from the cycle after the write. Results report the
// integer filtered voltage (20 mV per count) and the level: full, half,
// empty or critical.
module battery_level_filter_classifier (
  input  logic                        clk,
  input  logic                        rst,
  // Sample channel
  input  logic                        sample_valid,
  output logic                        sample_ready,
  input  logic [7:0]                  sample_voltage,
  // Result channel
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [7:0]                  filtered_voltage,
  output logic [1:0]                  battery_level,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [blfc_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [7:0]     okay_decivolts;
  logic [7:0]     warn_decivolts;
  logic [7:0]     critical_decivolts;
  blfc_pkg::thr_t thr;

  logic           in_valid;
  logic [7:0]     in_sample;
  logic           advance;
  logic           out_free;

  logic [15:0]    filter_acc;
  logic [15:0]    filter_acc_next;
  logic [15:0]    sample16;
  logic [15:0]    delta;
  logic [1:0]     level;
  logic [1:0]     level_next;
  logic [7:0]     fv;
  logic [7:0]     okay_lim;
  logic [7:0]     warn_lim;
  logic [7:0]     crit_lim;
  logic [1:0]     reg_index;

  // Configuration registers: written on the access phase of a write
  // transaction, always ready.
  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      okay_decivolts     <= blfc_pkg::OKAY_DEF;
      warn_decivolts     <= blfc_pkg::WARN_DEF;
      critical_decivolts <= blfc_pkg::CRIT_DEF;
    end else if (psel && penable && pwrite) begin
      case (reg_index)
        blfc_pkg::REG_OKAY: okay_decivolts     <= pwdata[7:0];
        blfc_pkg::REG_WARN: warn_decivolts     <= pwdata[7:0];
        blfc_pkg::REG_CRIT: critical_decivolts <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      blfc_pkg::REG_OKAY: prdata = {24'd0, okay_decivolts};
      blfc_pkg::REG_WARN: prdata = {24'd0, warn_decivolts};
      blfc_pkg::REG_CRIT: prdata = {24'd0, critical_decivolts};
      default:            prdata = 32'd0;
    endcase
  end

  blfc_thresholds u_thresholds (
    .clk      (clk),
    .rst      (rst),
    .okay_raw (okay_decivolts),
    .warn_raw (warn_decivolts),
    .crit_raw (critical_decivolts),
    .thr      (thr)
  );

  // Handshake: the result register frees up when empty or being taken, and
  // the input register moves on whenever the result register is free.
  assign out_free     = !result_valid || result_ready;
  assign advance      = in_valid && out_free;
  assign sample_ready = !in_valid || out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample_ready) begin
      in_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ready && sample_valid) begin
      in_sample <= sample_voltage;
    end
  end

  // Filter update: load while empty, else step a sixteenth of the gap,
  // truncating towards the present value.
  always_comb begin
    sample16 = {in_sample, 8'd0};
    if (sample16 > filter_acc) begin
      delta = sample16 - filter_acc;
    end else begin
      delta = filter_acc - sample16;
    end
    if (filter_acc == 16'd0) begin
      filter_acc_next = sample16;
    end else if (sample16 > filter_acc) begin
      filter_acc_next = filter_acc + (delta >> blfc_pkg::FilterShift);
    end else begin
      filter_acc_next = filter_acc - (delta >> blfc_pkg::FilterShift);
    end
    fv = filter_acc_next[15:8];
  end

  // Level decision with hysteresis on the threshold just above the
  // present level.
  always_comb begin
    okay_lim = thr.okay + ((level == blfc_pkg::LVL_HALF)  ? blfc_pkg::HYST_COUNTS : 8'd0);
    warn_lim = thr.warn + ((level == blfc_pkg::LVL_EMPTY) ? blfc_pkg::HYST_COUNTS : 8'd0);
    crit_lim = thr.crit + ((level == blfc_pkg::LVL_CRIT)  ? blfc_pkg::HYST_COUNTS : 8'd0);
    if (fv >= okay_lim) begin
      level_next = blfc_pkg::LVL_FULL;
    end else if (fv >= warn_lim) begin
      level_next = blfc_pkg::LVL_HALF;
    end else if (thr.crit_off || (fv >= crit_lim)) begin
      level_next = blfc_pkg::LVL_EMPTY;
    end else begin
      level_next = blfc_pkg::LVL_CRIT;
    end
  end

  // Filter and level state advance once per transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_acc <= 16'd0;
      level      <= blfc_pkg::LVL_FULL;
    end else if (advance) begin
      filter_acc <= filter_acc_next;
      level      <= level_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      filtered_voltage <= fv;
      battery_level    <= level_next;
    end
  end

endmodule

FILE: rtl/blfc_thresholds.sv
// ----------------------------------------------------------------------------
// Battery level filter and classifier: threshold sanitiser
// Turns the three raw decivolt registers into ordered, clamped thresholds in
// voltage counts and holds them in a register.
// ----------------------------------------------------------------------------
module blfc_thresholds (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       okay_raw,
  input  logic [7:0]       warn_raw,
  input  logic [7:0]       crit_raw,
  output blfc_pkg::thr_t   thr
);

  logic [7:0]     okay_c;
  logic [7:0]     warn_c;
  logic [7:0]     crit_c;
  logic [7:0]     warn_o;
  logic [7:0]     crit_o;
  blfc_pkg::thr_t thr_next;

  // Clamp each threshold, then push warn below okay and critical below warn.
  // Warn is never zero after clamping, so only its order against okay matters.
  always_comb begin
    okay_c = blfc_pkg::pick_and_clamp(okay_raw, blfc_pkg::OKAY_DEF,
                                      blfc_pkg::OKAY_MIN, blfc_pkg::OKAY_MAX);
    warn_c = blfc_pkg::pick_and_clamp(warn_raw, blfc_pkg::WARN_DEF,
                                      blfc_pkg::WARN_MIN, blfc_pkg::WARN_MAX);
    crit_c = blfc_pkg::pick_and_clamp(crit_raw, blfc_pkg::CRIT_DEF,
                                      blfc_pkg::CRIT_MIN, blfc_pkg::CRIT_MAX);
    warn_o = (okay_c <= warn_c) ? okay_c - 8'd1 : warn_c;
    crit_o = ((warn_o <= crit_c) && (crit_c != 8'd0)) ? warn_o - 8'd1 : crit_c;

    thr_next.okay     = blfc_pkg::times_five(okay_c);
    thr_next.warn     = blfc_pkg::times_five(warn_o);
    thr_next.crit     = blfc_pkg::times_five(crit_o);
    thr_next.crit_off = (crit_o == 8'd0);
  end

  // Registered thresholds; they follow a register write in the cycle after it.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr.okay     <= blfc_pkg::times_five(blfc_pkg::OKAY_DEF);
      thr.warn     <= blfc_pkg::times_five(blfc_pkg::WARN_DEF);
      thr.crit     <= blfc_pkg::times_five(blfc_pkg::CRIT_DEF);
      thr.crit_off <= 1'b0;
    end else begin
      thr <= thr_next;
    end
  end

endmodule
